FILE: rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and arithmetic helpers for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int CW     = 33;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
    localparam logic [29:0]          TURN_PER_RAD = 30'd683565276;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 1'd1;

    localparam logic [15:0] WHEEL_RADIUS_RST   = 16'd3277;
    localparam logic [15:0] INV_WHEEL_BASE_RST = 16'd1280;

    localparam logic ACTION_UPDATE   = 1'b0;
    localparam logic ACTION_SET_POSE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VR,
        S_VL,
        S_VSUM,
        S_DIFF,
        S_W,
        S_WTAKE,
        S_HDT,
        S_HABS,
        S_HHI,
        S_HLO,
        S_HSUM,
        S_HADD,
        S_WAITC,
        S_XC,
        S_XR,
        S_XD,
        S_XT,
        S_YC,
        S_YR,
        S_YD,
        S_YT,
        S_COMMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FIX,
        C_DONE
    } cordic_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_val;
        logic signed [CW-1:0] sin_val;
    } cordic_rsp_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            5'd24:   r = 30'd41;
            5'd25:   r = 30'd20;
            5'd26:   r = 30'd10;
            5'd27:   r = 30'd5;
            5'd28:   r = 30'd3;
            5'd29:   r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // shift right by n, rounding to nearest with ties toward plus infinity
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] p,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sum;
        half = PROD_W'(1) << (n - 1);
        sum  = p + half;
        return sum >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        logic signed [31:0]       r;
        max_v = PROD_W'(32'sh7FFF_FFFF);
        min_v = PROD_W'(32'sh8000_0000);
        if (v > max_v)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < min_v)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ddo_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_in_if
// Input channel: wheel speed update or set pose request.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] left_wheel_speed;
    logic [15:0]        time_step;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [31:0]        new_heading;

    modport source (
        output valid,
        input  ready,
        output action,
        output right_wheel_speed,
        output left_wheel_speed,
        output time_step,
        output new_x,
        output new_y,
        output new_heading
    );

    modport sink (
        input  valid,
        output ready,
        input  action,
        input  right_wheel_speed,
        input  left_wheel_speed,
        input  time_step,
        input  new_x,
        input  new_y,
        input  new_heading
    );
endinterface
`default_nettype wire

FILE: rtl/ddo_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_out_if
// Output channel: pose and most recent velocities.
// ----------------------------------------------------------------------------
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        pose_heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] yaw_rate;

    modport source (
        output valid,
        input  ready,
        output pose_x,
        output pose_y,
        output pose_heading,
        output linear_velocity,
        output yaw_rate
    );

    modport sink (
        input  valid,
        output ready,
        input  pose_x,
        input  pose_y,
        input  pose_heading,
        input  linear_velocity,
        input  yaw_rate
    );
endinterface
`default_nettype wire

FILE: rtl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cordic_req_t  req,
    output cordic_rsp_t       rsp
);

    cordic_state_t        state_reg;
    cordic_state_t        state_next;
    logic [STEP_W-1:0]    step_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic                 flip_reg;

    logic                 flip_in;
    logic [31:0]          folded;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [CW-1:0] atan_val;
    logic                 last_step;

    assign flip_in   = req.angle[31] ^ req.angle[30];
    assign folded    = {req.angle[31] ^ flip_in, req.angle[30:0]};
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign atan_val  = CW'(atan_turn(5'(step_reg)));
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  state_next = C_IDLE;
            C_RUN:   state_next = last_step ? C_FIX : C_RUN;
            C_FIX:   state_next = C_DONE;
            C_DONE:  state_next = C_DONE;
            default: state_next = C_IDLE;
        endcase
        if (req.start)
        begin
            state_next = C_RUN;
        end
    end

    always_comb
    begin
        rsp.done    = (state_reg == C_DONE);
        rsp.cos_val = x_reg;
        rsp.sin_val = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.start)
            begin
                step_reg <= '0;
            end
            else if (state_reg == C_RUN)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            z_reg    <= CW'($signed(folded));
            flip_reg <= flip_in;
        end
        else if (state_reg == C_RUN)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end
        end
        else if (state_reg == C_FIX && flip_reg)
        begin
            x_reg <= -x_reg;
            y_reg <= -y_reg;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (state_reg == C_RUN) && (step_reg == '0))
        else $error("cordic did not restart");

    a_last_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_RUN && last_step && !req.start) |=> (state_reg == C_FIX))
        else $error("cordic overran its step count");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.done && !req.start) |=> (rsp.done && $stable(x_reg) && $stable(y_reg)))
        else $error("cordic result changed while idle");

endmodule
`default_nettype wire

FILE: rtl/ddo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul
    import ddo_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]       prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry: integrates pose from wheel speeds, or loads a pose directly.
//
// request carries one transaction per wheel speed update or set pose; response
// returns the pose and the latest velocities for every request transaction.
// The config port writes the wheel radius (index 0) and inverse_wheel_base
// (index 1) on any edge with cfg_we high; write only while idle.
// For an update, a sequencer drives one shared multiplier through ten
// products, while a 16-step cordic (one micro-rotation per cycle) produces
// sine and cosine; the position products wait for the cordic. A set pose
// goes straight from idle to the commit state, which writes the pose once
// the response slot is free.
// request.ready is high only while the sequencer is idle, so one request is
// in work at a time. The response is held in the pose registers until taken;
// the next request may be accepted and worked on meanwhile, and its result
// waits until the pending response transaction completes.
// Reset clears the pose and velocities and restores the register defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ddo_in_if.sink                     request,
    ddo_out_if.source                  response
);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [15:0]        radius_reg;
    logic [15:0]        ibase_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic [31:0]        heading_reg;
    logic signed [31:0] lin_v_reg;
    logic signed [31:0] ang_v_reg;
    logic               out_valid_reg;

    logic               act_reg;
    logic signed [31:0] wr_reg;
    logic signed [31:0] wl_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] nx_reg;
    logic signed [31:0] ny_reg;
    logic [31:0]        nh_reg;

    logic signed [32:0]  vr_reg;
    logic signed [32:0]  vl_reg;
    logic signed [33:0]  diff_reg;
    logic signed [31:0]  v_reg;
    logic signed [31:0]  w_reg;
    logic                neg_reg;
    logic [47:0]         m_reg;
    logic [53:0]         hi_reg;
    logic [22:0]         frac_reg;
    logic [31:0]         mag_reg;
    logic signed [33:0]  rc_reg;
    logic signed [33:0]  dx_reg;
    logic signed [33:0]  dy_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_abs;
    logic [54:0]               frac_sum;

    cordic_req_t cordic_req;
    cordic_rsp_t cordic_rsp;

    logic accept;
    logic slot_free;
    logic commit;

    ddo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign accept    = request.valid && request.ready;
    assign slot_free = !out_valid_reg || response.ready;
    assign prod_abs  = prod[PROD_W-1] ? -prod : prod;
    assign frac_sum  = 55'({hi_reg[7:0], 24'd0}) + 55'(prod[53:0]) + 55'(32'h8000_0000);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = (request.action == ACTION_SET_POSE) ? S_COMMIT : S_VR;
                end
            end
            S_VR:     state_next = S_VL;
            S_VL:     state_next = S_VSUM;
            S_VSUM:   state_next = S_DIFF;
            S_DIFF:   state_next = S_W;
            S_W:      state_next = S_WTAKE;
            S_WTAKE:  state_next = S_HDT;
            S_HDT:    state_next = S_HABS;
            S_HABS:   state_next = S_HHI;
            S_HHI:    state_next = S_HLO;
            S_HLO:    state_next = S_HSUM;
            S_HSUM:   state_next = S_HADD;
            S_HADD:   state_next = S_WAITC;
            S_WAITC:  state_next = cordic_rsp.done ? S_XC : S_WAITC;
            S_XC:     state_next = S_XR;
            S_XR:     state_next = S_XD;
            S_XD:     state_next = S_XT;
            S_XT:     state_next = S_YC;
            S_YC:     state_next = S_YR;
            S_YR:     state_next = S_YD;
            S_YD:     state_next = S_YT;
            S_YT:     state_next = S_COMMIT;
            S_COMMIT: state_next = slot_free ? S_IDLE : S_COMMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        request.ready    = (state_reg == S_IDLE);
        cordic_req.start = 1'b0;
        cordic_req.angle = heading_reg;
        commit           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            S_IDLE:
            begin
                cordic_req.start = request.valid && (request.action == ACTION_UPDATE);
            end
            S_VR:
            begin
                mul_a = MUL_A_W'(wr_reg);
                mul_b = MUL_B_W'({1'b0, radius_reg});
            end
            S_VL:
            begin
                mul_a = MUL_A_W'(wl_reg);
                mul_b = MUL_B_W'({1'b0, radius_reg});
            end
            S_W:
            begin
                mul_a = diff_reg;
                mul_b = MUL_B_W'({1'b0, ibase_reg});
            end
            S_HDT:
            begin
                mul_a = MUL_A_W'(w_reg);
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            S_HHI:
            begin
                mul_a = MUL_A_W'({1'b0, m_reg[47:24]});
                mul_b = MUL_B_W'({1'b0, TURN_PER_RAD});
            end
            S_HLO:
            begin
                mul_a = MUL_A_W'({1'b0, m_reg[23:0]});
                mul_b = MUL_B_W'({1'b0, TURN_PER_RAD});
            end
            S_XC:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = cordic_rsp.cos_val;
            end
            S_XD:
            begin
                mul_a = rc_reg;
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            S_YC:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = cordic_rsp.sin_val;
            end
            S_YD:
            begin
                mul_a = rc_reg;
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            S_COMMIT:
            begin
                commit = slot_free;
            end
            default:
            begin
                commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            radius_reg    <= WHEEL_RADIUS_RST;
            ibase_reg     <= INV_WHEEL_BASE_RST;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            lin_v_reg     <= '0;
            ang_v_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WHEEL_RADIUS:   radius_reg <= cfg_data;
                    REG_INV_WHEEL_BASE: ibase_reg  <= cfg_data;
                    default:            radius_reg <= radius_reg;
                endcase
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (act_reg == ACTION_SET_POSE)
                begin
                    x_reg       <= nx_reg;
                    y_reg       <= ny_reg;
                    heading_reg <= nh_reg;
                end
                else
                begin
                    x_reg       <= clamp32(PROD_W'(x_reg) + PROD_W'(dx_reg));
                    y_reg       <= clamp32(PROD_W'(y_reg) + PROD_W'(dy_reg));
                    heading_reg <= neg_reg ? heading_reg - mag_reg : heading_reg + mag_reg;
                    lin_v_reg   <= v_reg;
                    ang_v_reg   <= w_reg;
                end
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= request.action;
            wr_reg  <= request.right_wheel_speed;
            wl_reg  <= request.left_wheel_speed;
            dt_reg  <= request.time_step;
            nx_reg  <= request.new_x;
            ny_reg  <= request.new_y;
            nh_reg  <= request.new_heading;
        end
        case (state_reg)
            S_VL:    vr_reg   <= 33'(round_shift(prod, 16));
            S_VSUM:  vl_reg   <= 33'(round_shift(prod, 16));
            S_DIFF:
            begin
                diff_reg <= 34'(vr_reg) - 34'(vl_reg);
                v_reg    <= clamp32(round_shift(PROD_W'(vr_reg) + PROD_W'(vl_reg), 1));
            end
            S_WTAKE: w_reg    <= clamp32(round_shift(prod, 8));
            S_HABS:
            begin
                neg_reg <= prod[PROD_W-1];
                m_reg   <= prod_abs[47:0];
            end
            S_HLO:   hi_reg   <= prod[53:0];
            S_HSUM:  frac_reg <= frac_sum[54:32];
            S_HADD:  mag_reg  <= hi_reg[39:8] + 32'(frac_reg);
            S_XR:    rc_reg   <= 34'(round_shift(prod, 30));
            S_XT:    dx_reg   <= 34'(round_shift(prod, 16));
            S_YR:    rc_reg   <= 34'(round_shift(prod, 30));
            S_YT:    dy_reg   <= 34'(round_shift(prod, 16));
            default: mag_reg  <= mag_reg;
        endcase
    end

    assign response.valid           = out_valid_reg;
    assign response.pose_x          = x_reg;
    assign response.pose_y          = y_reg;
    assign response.pose_heading    = heading_reg;
    assign response.linear_velocity = lin_v_reg;
    assign response.yaw_rate        = ang_v_reg;

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || response.ready))
        else $error("result written over a pending response");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !request.ready)
        else $error("new transaction taken while busy");

    a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XC || state_reg == S_YC) |-> cordic_rsp.done)
        else $error("position product used an unfinished cordic result");

    a_pose_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(heading_reg) && $stable(x_reg) && $stable(y_reg)))
        else $error("pose changed outside a commit");

endmodule
`default_nettype wire

FILE: sim/differential_drive_odometry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Self-checking bench for the wheel odometry block. A directed table covers
// pose loads at the range limits, extreme and opposed wheel speeds, zero and
// full time steps and heading wrap. Random phases follow, each with its own
// wheel radius and wheel base setting. Both channels stall at random, and one
// long response stall backs the block up. Every response is compared field
// by field to a typed-in pose or to a bit-exact pose integrator kept here.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb
    import ddo_pkg::*;
();

    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     PHASE_COUNT    = 8;
    localparam int     PHASE_ITEMS    = 200;
    localparam int     LONG_HOLD      = 300;
    localparam int     SETTLE_CYCLES  = 40;
    localparam longint COS_SEED       = 64'sd652032874;
    localparam longint RAD_TO_TURN    = 64'sd683565276;
    localparam longint POS_MAX        = 64'sd2147483647;
    localparam longint POS_MIN        = -64'sd2147483648;
    localparam longint ARCTAN_TURN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };
    // -1 selects a random setting
    localparam int RADIUS_PLAN [PHASE_COUNT] = '{3277, 65535, 0, 65535, 1, -1, 3277, -1};
    localparam int BASE_PLAN   [PHASE_COUNT] = '{1280, 65535, 0, 1, 0, -1, 65535, -1};

    typedef struct packed {
        logic               action;
        logic signed [31:0] right_speed;
        logic signed [31:0] left_speed;
        logic [15:0]        dt;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        heading;
    } odo_cmd_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        heading;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
    } pose_t;

    typedef struct packed {
        odo_cmd_t cmd;
        logic     typed_in;
        pose_t    pose;
    } trial_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ddo_in_if  request_ch ();
    ddo_out_if response_ch ();

    differential_drive_odometry u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .response  (response_ch)
    );

    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [31:0]        est_heading;
    logic signed [31:0] est_lin;
    logic signed [31:0] est_ang;
    logic [15:0]        radius_q16;
    logic [15:0]        inv_base_q8;

    pose_t pending_poses [$];
    int    mismatch_count = 0;
    int    cycle_count;
    bit    steady_traffic = 1'b0;
    bit    hold_response  = 1'b0;

    trial_t opening_table [19] = '{
        '{'{ACTION_UPDATE, 32'sh0, 32'sh0, 16'h0, 32'sh0, 32'sh0, 32'h0},
          1'b1, '{32'sh0, 32'sh0, 32'h0, 32'sh0, 32'sh0}},
        '{'{ACTION_UPDATE, 32'sh0, 32'sh0, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b1, '{32'sh0, 32'sh0, 32'h0, 32'sh0, 32'sh0}},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0},
          1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0, 32'sh0, 32'sh0}},
        '{'{ACTION_UPDATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh0001_0000, 32'shFFFF_0000, 16'h0, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'sh0, 32'sh0, 32'h4000_0000},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh0010_0000, 32'sh0010_0000, 16'h8000, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'h8000_0000}, 1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'sh0, 32'sh0, 32'hC000_0000},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'shFFFF_FFFF, 32'sh1, 32'hFFFF_FFFF},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh0005_0000, 32'sh0003_0000, 16'h1, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'shFFFF_FFFF, 32'sh1, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0},
        '{'{ACTION_SET_POSE, 32'sh0, 32'sh0, 16'h0, 32'sh0, 32'sh0, 32'h2000_0000},
          1'b0, '0},
        '{'{ACTION_UPDATE, 32'sh00A0_0000, 32'sh00A0_0000, 16'hFFFF, 32'sh0, 32'sh0, 32'h0},
          1'b0, '0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint rshift_round(input longint a, input int unsigned n);
        return (a + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat32(input longint a);
        if (a > POS_MAX)
        begin
            return POS_MAX;
        end
        if (a < POS_MIN)
        begin
            return POS_MIN;
        end
        return a;
    endfunction

    function automatic void heading_sincos(input logic [31:0] ang, output longint c,
                                           output longint s);
        logic   turned;
        longint x;
        longint y;
        longint z;
        longint nx;
        turned = ang[31] ^ ang[30];
        if (turned)
        begin
            ang = ang + 32'h8000_0000;
        end
        x = COS_SEED;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN_TURN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN_TURN[i];
            end
            x = nx;
        end
        c = turned ? -x : x;
        s = turned ? -y : y;
    endfunction

    // yaw rate times dt, converted to a binary angle, rounded to nearest with ties away from zero
    function automatic logic [31:0] heading_increment(input longint rate, input longint dt);
        longint      p;
        logic [95:0] m;
        logic [95:0] scaled;
        logic [31:0] d;
        p      = rate * dt;
        m      = 96'(p < 0 ? -p : p);
        scaled = (m * 96'(RAD_TO_TURN) + 96'h8000_0000) >> 32;
        d      = scaled[31:0];
        return (p < 0) ? -d : d;
    endfunction

    function automatic void reset_odometry();
        est_x       = '0;
        est_y       = '0;
        est_heading = '0;
        est_lin     = '0;
        est_ang     = '0;
        radius_q16  = 16'd3277;
        inv_base_q8 = 16'd1280;
    endfunction

    function automatic pose_t advance_odometry(input odo_cmd_t cmd);
        longint vr;
        longint vl;
        longint v;
        longint w;
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint dt;
        pose_t  r;
        if (cmd.action == ACTION_SET_POSE)
        begin
            est_x       = cmd.x;
            est_y       = cmd.y;
            est_heading = cmd.heading;
        end
        else
        begin
            dt = longint'(cmd.dt);
            vr = rshift_round(longint'($signed(cmd.right_speed)) * longint'(radius_q16), 16);
            vl = rshift_round(longint'($signed(cmd.left_speed)) * longint'(radius_q16), 16);
            v  = sat32(rshift_round(vr + vl, 1));
            w  = sat32(rshift_round((vr - vl) * longint'(inv_base_q8), 8));
            heading_sincos(est_heading, c, s);
            dx = rshift_round(rshift_round(v * c, 30) * dt, 16);
            dy = rshift_round(rshift_round(v * s, 30) * dt, 16);
            est_x       = 32'(sat32(longint'(est_x) + dx));
            est_y       = 32'(sat32(longint'(est_y) + dy));
            est_heading = est_heading + heading_increment(w, dt);
            est_lin     = 32'(v);
            est_ang     = 32'(w);
        end
        r.x       = est_x;
        r.y       = est_y;
        r.heading = est_heading;
        r.lin_vel = est_lin;
        r.ang_vel = est_ang;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_wheel_speed();
        logic signed [31:0] r;
        case ($urandom_range(0, 5))
            0:
            begin
                r = $urandom;
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       r = 32'sh7FFF_FFFF;
                    1:       r = 32'sh8000_0000;
                    2:       r = 32'sh0;
                    default: r = -32'sd1;
                endcase
            end
            default:
            begin
                r = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_time_step();
        logic [15:0] r;
        case ($urandom_range(0, 7))
            0:       r = 16'h0;
            1:       r = 16'hFFFF;
            2, 3:    r = 16'($urandom_range(0, 65535));
            default: r = 16'($urandom_range(1, 4096));
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_position();
        logic signed [31:0] r;
        case ($urandom_range(0, 3))
            0:       r = $urandom;
            1:       r = 32'sh7FFF_FFFF - $signed(32'($urandom_range(0, 32'h0040_0000)));
            2:       r = 32'sh8000_0000 + $signed(32'($urandom_range(0, 32'h0040_0000)));
            default: r = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
        endcase
        return r;
    endfunction

    function automatic odo_cmd_t random_command();
        odo_cmd_t cmd;
        cmd.action      = ($urandom_range(0, 4) == 0) ? ACTION_SET_POSE : ACTION_UPDATE;
        cmd.right_speed = pick_wheel_speed();
        case ($urandom_range(0, 3))
            0:       cmd.left_speed = cmd.right_speed;
            1:       cmd.left_speed = -cmd.right_speed;
            default: cmd.left_speed = pick_wheel_speed();
        endcase
        cmd.dt      = pick_time_step();
        cmd.x       = pick_position();
        cmd.y       = pick_position();
        cmd.heading = $urandom;
        return cmd;
    endfunction

    task automatic pause_requests(input int cycles);
        request_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic random_gap();
        if (!steady_traffic && $urandom_range(0, 3) == 0)
        begin
            pause_requests($urandom_range(1, 19));
        end
    endtask

    task automatic offer_command(input odo_cmd_t cmd, input logic typed_in, input pose_t pose);
        request_ch.valid             <= 1'b1;
        request_ch.action            <= cmd.action;
        request_ch.right_wheel_speed <= cmd.right_speed;
        request_ch.left_wheel_speed  <= cmd.left_speed;
        request_ch.time_step         <= cmd.dt;
        request_ch.new_x             <= cmd.x;
        request_ch.new_y             <= cmd.y;
        request_ch.new_heading       <= cmd.heading;
        do @(posedge clk); while (!request_ch.ready);
        if (typed_in)
        begin
            void'(advance_odometry(cmd));
            pending_poses.push_back(pose);
        end
        else
        begin
            pending_poses.push_back(advance_odometry(cmd));
        end
    endtask

    task automatic drain_results();
        request_ch.valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] radius, input logic [15:0] inv_base);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WHEEL_RADIUS;
        cfg_data  <= radius;
        @(posedge clk);
        cfg_index <= REG_INV_WHEEL_BASE;
        cfg_data  <= inv_base;
        @(posedge clk);
        cfg_we      <= 1'b0;
        radius_q16  = radius;
        inv_base_q8 = inv_base;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: response transaction with nothing expected, expected none actual %h",
                         $time, {response_ch.pose_x, response_ch.pose_y});
                mismatch_count++;
            end
            else
            begin
                want = pending_poses.pop_front();
                check_field("pose_x", want.x, response_ch.pose_x);
                check_field("pose_y", want.y, response_ch.pose_y);
                check_field("pose_heading", want.heading, response_ch.pose_heading);
                check_field("linear_velocity", want.lin_vel, response_ch.linear_velocity);
                check_field("yaw_rate", want.ang_vel, response_ch.yaw_rate);
            end
        end
    end

    // response side back-pressure
    initial
    begin
        int held;
        response_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_response)
            begin
                hold_response = 1'b0;
                response_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
            end
            else if (!steady_traffic && $urandom_range(0, 3) == 0)
            begin
                response_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [15:0] radius;
        logic [15:0] inv_base;
        rst_n                        <= 1'b0;
        cfg_we                       <= 1'b0;
        cfg_index                    <= '0;
        cfg_data                     <= '0;
        request_ch.valid             <= 1'b0;
        request_ch.action            <= ACTION_UPDATE;
        request_ch.right_wheel_speed <= '0;
        request_ch.left_wheel_speed  <= '0;
        request_ch.time_step         <= '0;
        request_ch.new_x             <= '0;
        request_ch.new_y             <= '0;
        request_ch.new_heading       <= '0;
        reset_odometry();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_table[i])
        begin
            random_gap();
            offer_command(opening_table[i].cmd, opening_table[i].typed_in,
                          opening_table[i].pose);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            radius   = (RADIUS_PLAN[phase] < 0) ? 16'($urandom) : 16'(RADIUS_PLAN[phase]);
            inv_base = (BASE_PLAN[phase] < 0) ? 16'($urandom) : 16'(BASE_PLAN[phase]);
            load_settings(radius, inv_base);
            steady_traffic = (phase == PHASE_COUNT - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // back the block up behind a stalled response
                if (phase == 1 && n == 40)
                begin
                    hold_response = 1'b1;
                end
                random_gap();
                offer_command(random_command(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
